// ===== rtl/core/gbf_pkg.sv =====
// ----------------------------------------------------------------------------
// gbf_pkg
// Shared types and constants for the GB2312 text to font ROM address block.
// ----------------------------------------------------------------------------
package gbf_pkg;

  // Configuration register indexes.
  localparam logic CFG_IDX_HANZI_OFFSET = 1'b0;
  localparam logic CFG_IDX_ASCII_BASE   = 1'b1;

  // Configuration reset values.
  localparam logic [15:0] HANZI_OFFSET_RST = 16'd846;
  localparam logic [23:0] ASCII_BASE_RST   = 24'h03cf80;

  // Byte ranges of the encoding.
  localparam logic [7:0] HANZI_LEAD_LO  = 8'hb0;
  localparam logic [7:0] HANZI_LEAD_HI  = 8'hf7;
  localparam logic [7:0] SYMBOL_LEAD_LO = 8'ha1;
  localparam logic [7:0] SYMBOL_LEAD_HI = 8'ha3;
  localparam logic [7:0] TRAIL_LO       = 8'ha1;
  localparam logic [7:0] ASCII_LO       = 8'h20;
  localparam logic [7:0] ASCII_HI       = 8'h7e;
  localparam logic [7:0] END_BYTE       = 8'h00;

  // Glyphs per row of the two-byte code table.
  localparam logic [6:0] ROW_GLYPHS = 7'd94;

  // Cursor advance for each glyph width.
  localparam logic [7:0] WIDE_ADVANCE  = 8'd16;
  localparam logic [7:0] ASCII_ADVANCE = 8'd8;

  // Glyph class codes.
  localparam logic [1:0] CLASS_HANZI  = 2'd0;
  localparam logic [1:0] CLASS_SYMBOL = 2'd1;
  localparam logic [1:0] CLASS_ASCII  = 2'd2;

  // One input word.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_start;
    logic [7:0] start_column;
    logic [2:0] start_page;
  } gbf_item_t;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic       lead_held;
    logic [7:0] lead_value;
    logic [7:0] cursor_column;
    logic [2:0] cursor_page;
    logic       string_ended;
  } gbf_state_t;

  // One result word.
  typedef struct packed {
    logic [23:0] font_address;
    logic [1:0]  glyph_class;
    logic [7:0]  draw_column;
    logic [2:0]  draw_page;
  } gbf_result_t;

  localparam gbf_state_t STATE_RST = '{
    lead_held:     1'b0,
    lead_value:    8'h00,
    cursor_column: 8'h00,
    cursor_page:   3'd0,
    string_ended:  1'b1
  };

endpackage

// ===== rtl/core/gbf_in_reg.sv =====
// ----------------------------------------------------------------------------
// gbf_in_reg
// Input register: captures one word and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
module gbf_in_reg
  import gbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  gbf_item_t  in_item,
  output logic       item_vld,
  output gbf_item_t  item,
  input  logic       item_take
);

  logic      vld_r;
  logic      vld_nxt;
  gbf_item_t item_r;

  // The register may load when it is empty or is being emptied this cycle.
  assign in_ready = !vld_r || item_take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (item_take) begin
      vld_nxt = 1'b0;
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== rtl/core/gbf_decode.sv =====
// ----------------------------------------------------------------------------
// gbf_decode
// Byte decoder: from the held state and one byte, works out the next state
// and, for a complete glyph, its font ROM address and screen position.
// ----------------------------------------------------------------------------
module gbf_decode
  import gbf_pkg::*;
(
  input  gbf_item_t   item,
  input  gbf_state_t  st,
  input  logic [15:0] hanzi_offset,
  input  logic [23:0] ascii_base,
  output gbf_state_t  st_nxt,
  output logic        emit,
  output gbf_result_t res
);

  logic       b_is_hanzi_lead;
  logic       b_is_symbol_lead;
  logic       b_is_ascii;
  logic       lead_is_hanzi;
  logic [6:0] row;
  logic [6:0] trail;
  logic [12:0] row_base;
  logic [16:0] wide_index;
  logic [23:0] wide_address;
  logic [23:0] ascii_address;

  // Byte classification.
  assign b_is_hanzi_lead  = (item.text_byte >= HANZI_LEAD_LO) &&
                            (item.text_byte <= HANZI_LEAD_HI);
  assign b_is_symbol_lead = (item.text_byte >= SYMBOL_LEAD_LO) &&
                            (item.text_byte <= SYMBOL_LEAD_HI);
  assign b_is_ascii       = (item.text_byte >= ASCII_LO) &&
                            (item.text_byte <= ASCII_HI);
  assign lead_is_hanzi    = (st.lead_value >= HANZI_LEAD_LO) &&
                            (st.lead_value <= HANZI_LEAD_HI);

  // Two-byte glyph index: row times 94 plus trail, plus the hanzi offset for hanzi leads.
  // Only hanzi and symbol leads are ever held, so anything else is a symbol.
  always_comb begin
    logic [7:0] row_full;
    logic [7:0] trail_full;
    row_full   = lead_is_hanzi ? (st.lead_value - HANZI_LEAD_LO)
                               : (st.lead_value - SYMBOL_LEAD_LO);
    trail_full = item.text_byte - TRAIL_LO;
    row        = row_full[6:0];
    trail      = trail_full[6:0];
  end

  assign row_base      = {6'd0, row} * {6'd0, ROW_GLYPHS};
  assign wide_index    = {4'd0, row_base} + {10'd0, trail} +
                         (lead_is_hanzi ? {1'b0, hanzi_offset} : 17'd0);
  assign wide_address  = {2'b00, wide_index, 5'b00000};
  assign ascii_address = ascii_base +
                         {12'd0, item.text_byte - ASCII_LO, 4'b0000};

  // State update and result selection.
  always_comb begin
    gbf_state_t s;
    logic       done;
    s    = st;
    done = 1'b0;
    emit = 1'b0;
    res  = '{font_address: ascii_address, glyph_class: CLASS_ASCII,
             draw_column: st.cursor_column, draw_page: st.cursor_page};

    // A string start reloads the cursor, drops any held lead and reopens the string.
    if (item.string_start) begin
      s.cursor_column = item.start_column;
      s.cursor_page   = item.start_page;
      s.lead_held     = 1'b0;
      s.lead_value    = 8'h00;
      s.string_ended  = 1'b0;
    end
    res.draw_column = s.cursor_column;
    res.draw_page   = s.cursor_page;

    if (!s.string_ended) begin
      if (item.text_byte == END_BYTE) begin
        s.string_ended = 1'b1;
        s.lead_held    = 1'b0;
        s.lead_value   = 8'h00;
      end else begin
        // A held lead is always consumed; it forms a glyph with a valid trail.
        if (s.lead_held) begin
          s.lead_held  = 1'b0;
          s.lead_value = 8'h00;
          if (item.text_byte >= TRAIL_LO) begin
            done             = 1'b1;
            emit             = 1'b1;
            res.font_address = wide_address;
            res.glyph_class  = lead_is_hanzi ? CLASS_HANZI : CLASS_SYMBOL;
            s.cursor_column  = s.cursor_column + WIDE_ADVANCE;
          end
        end
        // Otherwise the byte is handled on its own.
        if (!done) begin
          if (b_is_hanzi_lead || b_is_symbol_lead) begin
            s.lead_held  = 1'b1;
            s.lead_value = item.text_byte;
          end else if (b_is_ascii) begin
            emit            = 1'b1;
            s.cursor_column = s.cursor_column + ASCII_ADVANCE;
          end
        end
      end
    end
    st_nxt = s;
  end

endmodule

// ===== rtl/core/gb2312_text_to_font_rom_address.sv =====
// ----------------------------------------------------------------------------
// gb2312_text_to_font_rom_address
// Turns a GB2312 byte stream into font ROM addresses and screen positions.
//
//   Channel  Handshake               Word
//   in       in_valid / in_ready     text byte, string start, column, page
//   out      out_valid / out_ready   font address, class, column, page
//   cfg      cfg_write_en            register index and data, no wait
//
// One byte is taken per cycle unless the output stalls. A byte passes the input
// register, is decoded against the held lead and cursor, and its glyph is then
// written into the output register. A stalled output still lets one more
// byte into the input register. Reset is synchronous and clears the cursor,
// the held lead and both registers' valid flags; the string starts ended.
// ----------------------------------------------------------------------------
module gb2312_text_to_font_rom_address
  import gbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_string_start,
  input  logic [7:0]  in_start_column,
  input  logic [2:0]  in_start_page,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_font_address,
  output logic [1:0]  out_glyph_class,
  output logic [7:0]  out_draw_column,
  output logic [2:0]  out_draw_page,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  gbf_item_t   in_item;
  gbf_item_t   item;
  logic        item_vld;
  logic        item_take;
  gbf_state_t  state_r;
  gbf_state_t  state_nxt;
  logic        emit;
  gbf_result_t res;
  gbf_result_t res_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [15:0] hanzi_offset_r;
  logic [23:0] ascii_base_r;

  assign in_item = '{text_byte: in_text_byte, string_start: in_string_start,
                     start_column: in_start_column, start_page: in_start_page};

  // Input register.
  gbf_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take)
  );

  // Decoder.
  gbf_decode u_decode (
    .item         (item),
    .st           (state_r),
    .hanzi_offset (hanzi_offset_r),
    .ascii_base   (ascii_base_r),
    .st_nxt       (state_nxt),
    .emit         (emit),
    .res          (res)
  );

  // A held word is decoded when the output register is free or draining.
  assign item_take = item_vld && (!out_valid_r || out_ready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hanzi_offset_r <= HANZI_OFFSET_RST;
      ascii_base_r   <= ASCII_BASE_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_IDX_HANZI_OFFSET: hanzi_offset_r <= cfg_data[15:0];
        CFG_IDX_ASCII_BASE:   ascii_base_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (item_take) begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item_take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_font_address = res_r.font_address;
  assign out_glyph_class  = res_r.glyph_class;
  assign out_draw_column  = res_r.draw_column;
  assign out_draw_page    = res_r.draw_page;

endmodule

// ===== rtl/core/gbf_checker.sv =====
// ----------------------------------------------------------------------------
// gbf_checker
// Port-level checks for the font ROM address block, bound to the top level.
// ----------------------------------------------------------------------------
module gbf_checker
  import gbf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_font_address,
  input logic [1:0]  out_glyph_class
);

  // A word waiting at the output is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  // Only the three defined glyph classes appear.
  a_class_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_glyph_class == CLASS_HANZI) ||
                  (out_glyph_class == CLASS_SYMBOL) ||
                  (out_glyph_class == CLASS_ASCII))
    else $error("undefined glyph class");

  // Wide glyphs are 32-byte aligned in the font ROM.
  a_wide_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_glyph_class != CLASS_ASCII) |-> out_font_address[4:0] == 5'd0)
    else $error("wide glyph address not aligned");

  // Input is held off only while the output word is stalled.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

endmodule

bind gb2312_text_to_font_rom_address gbf_checker u_gbf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_font_address (out_font_address),
  .out_glyph_class  (out_glyph_class)
);
